// ----- hw/rtl/scbi_pkg.sv -----
`default_nettype none

package scbi_pkg;

  // Field widths of one request and one result.
  localparam int unsigned FuncW   = 3;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned PhysW   = 21;
  localparam int unsigned MixW    = 17;
  localparam int unsigned BankOffW = 14;
  localparam int unsigned ChanCount = 4;
  localparam int unsigned ChanIdxW  = 2;

  // Highest page number that is taken into the memory map.
  localparam logic [DataW-1:0] RamPageCount = 8'd64;

  // Snooped DAC window: address bits 15:13 equal to this select 0x6000-0x7FFF.
  localparam logic [2:0] SnoopTop = 3'b011;

  localparam logic [DataW-1:0] AllOnes = 8'hFF;

  typedef enum logic [FuncW-1:0] {
    FuncMemRead  = 3'd0,
    FuncMemWrite = 3'd1,
    FuncIoIn     = 3'd2,
    FuncIoOut    = 3'd3,
    FuncTick     = 3'd4,
    FuncHostCmd  = 3'd5,
    FuncHostData = 3'd6
  } scbi_func_e;

  typedef enum logic [3:0] {
    PortPage     = 4'h0,
    PortCommand  = 4'h1,
    PortHostData = 4'h2,
    PortToHost   = 4'h3,
    PortStatus   = 4'h4,
    PortClrCmd   = 4'h5,
    PortVol0     = 4'h6,
    PortVol1     = 4'h7,
    PortVol2     = 4'h8,
    PortVol3     = 4'h9,
    PortPageFlag = 4'hA,
    PortVolFlag  = 4'hB
  } scbi_port_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;
  } scbi_req_t;

  typedef struct packed {
    logic [PhysW-1:0] phys_addr;
    logic             is_rom;
    logic             write_enable;
    logic [DataW-1:0] read_data;
    logic [MixW-1:0]  mix_left;
    logic [MixW-1:0]  mix_right;
    logic [DataW-1:0] status_out;
    logic [DataW-1:0] to_host_data;
  } scbi_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sound_card_bus_interface_core.sv -----
`default_nettype none

// Sound card bus interface. Each request (a memory read or write, an I/O
// in or out, a sample tick, or a host command or data byte) yields exactly
// one result. A request is captured in an input register, worked on in one
// pass of short logic against the card state, and the result lands in an
// output register; the card state updates in that same cycle. The block
// takes one request per clock while out_ready_i does not hold a result
// back. A request passes the input register and then the output register,
// and the input register lets one more request enter while the previous
// result waits to be collected.
// Memory addresses go through four 16K banks: bank 0 is ROM, bank 1 is RAM
// at 16K, and banks 2 and 3 are ROM while the page is 0, otherwise RAM at
// 32K times (page - 1). A page number above the RAM page count is kept for
// reading back but leaves the mapping as it was. A memory read inside
// 0x6000-0x7FFF also latches the byte into one of four DAC channels, and a
// sample tick returns left and right mixes of volume times channel. There
// is no clearing pass after reset.
module sound_card_bus_interface_core import scbi_pkg::*; #(
  parameter logic [DataW-1:0] RamPages = RamPageCount
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,

  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire scbi_req_t in_req_i,

  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output scbi_rsp_t      out_rsp_o
);

  logic      in_valid_q;
  scbi_req_t in_req_q;
  logic      out_valid_q;
  scbi_rsp_t out_rsp_q;
  scbi_rsp_t exec_rsp;
  logic      advance;

  // The held request moves on whenever the output register is free or
  // being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  scbi_exec #(
    .RamPages (RamPages)
  ) u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_req_q),
    .rsp_o  (exec_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= exec_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ----- hw/rtl/scbi_map.sv -----
`default_nettype none

// Bank translation of a CPU memory address into a ROM or RAM byte address.
module scbi_map import scbi_pkg::*; (
  input  wire logic [AddrW-1:0] address_i,
  input  wire logic [DataW-1:0] mapped_page_i,
  output logic      [PhysW-1:0] phys_addr_o,
  output logic                  is_rom_o
);

  logic [1:0]          bank;
  logic [BankOffW-1:0] offset;
  logic [DataW-1:0]    page_m1;

  assign bank    = address_i[AddrW-1:AddrW-2];
  assign offset  = address_i[BankOffW-1:0];
  assign page_m1 = mapped_page_i - 8'd1;

  always_comb begin
    unique case (bank)
      2'd0: begin
        is_rom_o    = 1'b1;
        phys_addr_o = PhysW'(offset);
      end
      2'd1: begin
        is_rom_o    = 1'b0;
        phys_addr_o = PhysW'({1'b1, offset});
      end
      default: begin
        if (mapped_page_i == '0) begin
          is_rom_o    = 1'b1;
          phys_addr_o = PhysW'({bank[0], offset});
        end else begin
          // Each RAM page is two banks wide; the sum wraps to the result width.
          is_rom_o    = 1'b0;
          phys_addr_o = PhysW'({page_m1, bank[0], offset});
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scbi_exec.sv -----
`default_nettype none

// Card state and the per-request work: memory mapping, DAC snooping,
// port decode and the sample mix. State advances when fire_i is high.
module scbi_exec import scbi_pkg::*; #(
  parameter logic [DataW-1:0] RamPages = RamPageCount
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire scbi_req_t req_i,
  output scbi_rsp_t      rsp_o
);

  logic [DataW-1:0] current_page_q, current_page_d;
  logic [DataW-1:0] mapped_page_q, mapped_page_d;
  logic [DataW-1:0] status_q, status_d;
  logic [DataW-1:0] command_q, command_d;
  logic [DataW-1:0] from_host_q, from_host_d;
  logic [DataW-1:0] to_host_q, to_host_d;
  logic [DataW-1:0] volume_q [ChanCount];
  logic [DataW-1:0] volume_d [ChanCount];
  logic [DataW-1:0] sample_q [ChanCount];
  logic [DataW-1:0] sample_d [ChanCount];

  logic [PhysW-1:0]  map_phys;
  logic              map_rom;
  logic [3:0]        port;
  logic [ChanIdxW-1:0] vol_idx;
  logic [ChanIdxW-1:0] snoop_idx;
  logic [2*DataW-1:0] prod0, prod1, prod2, prod3;

  scbi_map u_map (
    .address_i     (req_i.address),
    .mapped_page_i (mapped_page_q),
    .phys_addr_o   (map_phys),
    .is_rom_o      (map_rom)
  );

  assign port      = req_i.address[3:0];
  assign vol_idx   = ChanIdxW'(port - PortVol0);
  assign snoop_idx = req_i.address[9:8];

  assign prod0 = volume_q[0] * sample_q[0];
  assign prod1 = volume_q[1] * sample_q[1];
  assign prod2 = volume_q[2] * sample_q[2];
  assign prod3 = volume_q[3] * sample_q[3];

  always_comb begin
    current_page_d = current_page_q;
    mapped_page_d  = mapped_page_q;
    status_d       = status_q;
    command_d      = command_q;
    from_host_d    = from_host_q;
    to_host_d      = to_host_q;
    volume_d       = volume_q;
    sample_d       = sample_q;

    rsp_o = '0;

    unique case (req_i.func)
      FuncMemRead: begin
        rsp_o.phys_addr = map_phys;
        rsp_o.is_rom    = map_rom;
        rsp_o.read_data = req_i.data;
        if (req_i.address[AddrW-1:AddrW-3] == SnoopTop) begin
          sample_d[snoop_idx] = req_i.data;
        end
      end
      FuncMemWrite: begin
        rsp_o.phys_addr    = map_phys;
        rsp_o.is_rom       = map_rom;
        rsp_o.write_enable = !map_rom;
      end
      FuncIoIn: begin
        rsp_o.read_data = AllOnes;
        unique case (port)
          PortCommand:  rsp_o.read_data = command_q;
          PortHostData: begin
            status_d[7]     = 1'b0;
            rsp_o.read_data = from_host_q;
          end
          PortToHost: begin
            status_d[7] = 1'b1;
            from_host_d = AllOnes;
          end
          PortStatus:   rsp_o.read_data = status_q;
          PortClrCmd:   status_d[0] = 1'b0;
          PortPageFlag: status_d[7] = current_page_q[0];
          PortVolFlag:  status_d[0] = volume_q[0][5];
          default: ;
        endcase
      end
      FuncIoOut: begin
        unique case (port)
          PortPage: begin
            current_page_d = req_i.data;
            if (req_i.data <= RamPages) begin
              mapped_page_d = req_i.data;
            end
          end
          PortHostData: status_d[7] = 1'b0;
          PortToHost: begin
            to_host_d   = req_i.data;
            status_d[7] = 1'b1;
          end
          PortClrCmd: status_d[0] = 1'b0;
          PortVol0, PortVol1, PortVol2, PortVol3: volume_d[vol_idx] = req_i.data;
          PortPageFlag: status_d[7] = current_page_q[0];
          PortVolFlag:  status_d[0] = volume_q[0][5];
          default: ;
        endcase
      end
      FuncTick: begin
        rsp_o.mix_left  = {1'b0, prod0} + {1'b0, prod3};
        rsp_o.mix_right = {1'b0, prod1} + {1'b0, prod2};
      end
      FuncHostCmd:  command_d   = req_i.data;
      FuncHostData: from_host_d = req_i.data;
      default: ;
    endcase

    rsp_o.status_out   = status_d;
    rsp_o.to_host_data = to_host_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_page_q <= '0;
      mapped_page_q  <= '0;
      status_q       <= AllOnes;
      command_q      <= '0;
      from_host_q    <= '0;
      to_host_q      <= '0;
      for (int i = 0; i < ChanCount; i++) begin
        volume_q[i] <= '0;
        sample_q[i] <= '0;
      end
    end else if (fire_i) begin
      current_page_q <= current_page_d;
      mapped_page_q  <= mapped_page_d;
      status_q       <= status_d;
      command_q      <= command_d;
      from_host_q    <= from_host_d;
      to_host_q      <= to_host_d;
      volume_q       <= volume_d;
      sample_q       <= sample_d;
    end
  end

endmodule

`default_nettype wire

// ----- sim/sound_card_bus_interface_core_tb.sv -----
module sound_card_bus_interface_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scbi_pkg::*;

  // Bytes in one memory bank; banks 2 and 3 of a RAM page sit 32K apart per page.
  localparam int unsigned BankBytes = 1 << BankOffW;

  // The func encoding that the block has no meaning for; it must be ignored.
  localparam logic [FuncW-1:0] FuncUnused = 3'd7;

  localparam int unsigned DirectedItems = 25;
  localparam int unsigned RandomItems   = 1625;
  // Requests counted between these two marks run with no idling on either side.
  localparam int unsigned SteadyFrom    = 700;
  localparam int unsigned SteadyTo      = 1000;
  // Margin waited after the last expected result has arrived; this is plenty.
  localparam int unsigned DrainCycles   = 16;
  // Bound on the clock count of the whole run; this is far above what it needs.
  localparam int unsigned CycleLimit    = 200000;

  // Tracks the card state, works out the result of each accepted request and
  // holds those results until the block returns them.
  class bus_result_board;
    logic [DataW-1:0] cur_page;
    logic [DataW-1:0] map_page;
    logic [DataW-1:0] status;
    logic [DataW-1:0] command;
    logic [DataW-1:0] host_in;
    logic [DataW-1:0] host_out;
    logic [DataW-1:0] volume [ChanCount];
    logic [DataW-1:0] sample [ChanCount];
    scbi_rsp_t        awaited [$];
    int unsigned      fails;
    int unsigned      seen;

    function new();
      cur_page = '0;
      map_page = '0;
      status   = AllOnes;
      command  = '0;
      host_in  = '0;
      host_out = '0;
      foreach (volume[i]) volume[i] = '0;
      foreach (sample[i]) sample[i] = '0;
      fails = 0;
      seen  = 0;
    endfunction

    function void note_req(scbi_req_t r);
      scbi_rsp_t   e;
      int unsigned phys;
      int unsigned left;
      int unsigned right;
      logic [1:0]  bank;
      logic [3:0]  port;
      e    = '0;
      bank = r.address[AddrW-1 -: 2];
      port = r.address[3:0];
      phys = r.address[BankOffW-1:0];

      // Flag ports behave the same whether the CPU reads or writes them.
      if (r.func == FuncIoIn || r.func == FuncIoOut) begin
        case (port)
          PortHostData: status[7] = 1'b0;
          PortClrCmd:   status[0] = 1'b0;
          PortPageFlag: status[7] = cur_page[0];
          PortVolFlag:  status[0] = volume[0][5];
          default: ;
        endcase
      end

      case (r.func)
        FuncMemRead, FuncMemWrite: begin
          // Bank 0 is always ROM; banks 2 and 3 are ROM only while page 0 is mapped.
          e.is_rom = (bank == 2'd0) || (bank[1] && map_page == '0);
          if (bank == 2'd1) begin
            phys += BankBytes;
          end else if (bank[1]) begin
            if (bank[0]) phys += BankBytes;
            if (map_page != '0) phys += (map_page - 1) * 2 * BankBytes;
          end
          e.phys_addr = PhysW'(phys);
          if (r.func == FuncMemRead) begin
            e.read_data = r.data;
            // Reads in 0x6000-0x7FFF feed the DAC channel picked by address bits 9:8.
            if (r.address[AddrW-1 -: 3] == SnoopTop) sample[r.address[9:8]] = r.data;
          end else begin
            e.write_enable = !e.is_rom;
          end
        end
        FuncIoIn: begin
          e.read_data = AllOnes;
          case (port)
            PortCommand:  e.read_data = command;
            PortHostData: e.read_data = host_in;
            PortToHost: begin
              status[7] = 1'b1;
              host_in   = AllOnes;
            end
            PortStatus:   e.read_data = status;
            default: ;
          endcase
        end
        FuncIoOut: begin
          case (port)
            PortPage: begin
              cur_page = r.data;
              // A page beyond the RAM is remembered but does not change the map.
              if (r.data <= RamPageCount) map_page = r.data;
            end
            PortToHost: begin
              host_out  = r.data;
              status[7] = 1'b1;
            end
            PortVol0, PortVol1, PortVol2, PortVol3: volume[port - PortVol0] = r.data;
            default: ;
          endcase
        end
        FuncTick: begin
          left        = volume[0] * sample[0] + volume[3] * sample[3];
          right       = volume[1] * sample[1] + volume[2] * sample[2];
          e.mix_left  = MixW'(left);
          e.mix_right = MixW'(right);
        end
        FuncHostCmd:  command = r.data;
        FuncHostData: host_in = r.data;
        default: ;
      endcase

      e.status_out   = status;
      e.to_host_data = host_out;
      awaited.push_back(e);
    endfunction

    task report(string msg);
      fails++;
      $display("[%0t] result %0d: %s", $realtime, seen, msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_rsp(scbi_rsp_t got);
      scbi_rsp_t want;
      if (awaited.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      want = awaited.pop_front();
      cmp_field("phys_addr",    got.phys_addr,    want.phys_addr);
      cmp_field("is_rom",       got.is_rom,       want.is_rom);
      cmp_field("write_enable", got.write_enable, want.write_enable);
      cmp_field("read_data",    got.read_data,    want.read_data);
      cmp_field("mix_left",     got.mix_left,     want.mix_left);
      cmp_field("mix_right",    got.mix_right,    want.mix_right);
      cmp_field("status_out",   got.status_out,   want.status_out);
      cmp_field("to_host_data", got.to_host_data, want.to_host_data);
      seen++;
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  scbi_req_t in_req_i;
  logic      out_valid_o;
  logic      out_ready_i;
  scbi_rsp_t out_rsp_o;

  bus_result_board board;
  bit              steady;
  int unsigned     cycles;

  sound_card_bus_interface_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Both handshakes are sampled on the clock edge itself, before any of the
  // nonblocking updates of that edge land. The request is noted first so that
  // a result returned in the same cycle would still find its expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_req(in_req_i);
      if (out_valid_o && out_ready_i) board.check_rsp(out_rsp_o);
    end
  end

  // The result side stalls in roughly 18 percent of cycles, except during
  // the steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 18);
  end

  // A hung block must not hang the run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it. After the
  // handshake the sender idles with valid low after about 22 requests of a
  // hundred.
  task automatic issue_req(logic [FuncW-1:0] f, logic [AddrW-1:0] a, logic [DataW-1:0] d);
    in_valid_i       <= 1'b1;
    in_req_i.func    <= f;
    in_req_i.address <= a;
    in_req_i.data    <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!steady && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    logic [FuncW-1:0] f;
    logic [AddrW-1:0] a;
    logic [DataW-1:0] d;
    int unsigned      pick;
    int unsigned      counted;

    board       = new();
    steady      = 1'b0;
    cycles      = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every function, the blocked ROM write,
    // the too-large page, unused ports and the unused function code.
    issue_req(FuncMemRead,  16'h0000, 8'h00);
    issue_req(FuncMemWrite, 16'hFFFF, 8'hFF);
    issue_req(FuncIoOut,    AddrW'(PortVol0), 8'hFF);
    issue_req(FuncIoOut,    AddrW'(PortVol3), 8'h20);
    issue_req(FuncMemRead,  16'h6000, 8'hFF);
    issue_req(FuncMemRead,  16'h7FFF, 8'hFF);
    issue_req(FuncTick,     16'h0000, 8'h00);
    issue_req(FuncHostCmd,  16'hFFFF, 8'h5A);
    issue_req(FuncHostData, 16'h0000, 8'hA5);
    issue_req(FuncIoIn,     AddrW'(PortCommand), 8'h00);
    issue_req(FuncIoIn,     AddrW'(PortHostData), 8'h00);
    issue_req(FuncIoIn,     AddrW'(PortToHost), 8'h00);
    issue_req(FuncIoIn,     AddrW'(PortStatus), 8'h00);
    issue_req(FuncIoIn,     AddrW'(PortClrCmd), 8'h00);
    issue_req(FuncIoIn,     AddrW'(PortVolFlag), 8'h00);
    issue_req(FuncIoOut,    AddrW'(PortToHost), 8'h81);
    issue_req(FuncIoOut,    AddrW'(PortPage), RamPageCount + 8'd1);
    issue_req(FuncIoIn,     AddrW'(PortPageFlag), 8'h00);
    issue_req(FuncMemWrite, 16'h8000, 8'h11);
    issue_req(FuncIoOut,    AddrW'(PortPage), RamPageCount);
    issue_req(FuncMemWrite, 16'hFFFF, 8'h22);
    issue_req(FuncIoIn,     16'hFFFF, 8'hFF);
    issue_req(FuncUnused,   16'hFFFF, 8'hFF);
    issue_req(FuncIoOut,    {12'hFFF, PortHostData}, 8'hFF);
    issue_req(FuncTick,     16'hFFFF, 8'hFF);

    // Random part. Memory traffic dominates, with many reads aimed at the DAC
    // window and page writes that mostly land in range so RAM banks get used.
    counted = 0;
    while (counted < RandomItems) begin
      steady = (counted >= SteadyFrom) && (counted < SteadyTo);
      pick   = $urandom_range(99);
      a      = AddrW'($urandom);
      d      = DataW'($urandom);
      if (pick < 25) begin
        f = FuncMemRead;
        if ($urandom_range(9) < 4) a[AddrW-1 -: 3] = SnoopTop;
      end else if (pick < 45) begin
        f = FuncMemWrite;
      end else if (pick < 60) begin
        f = FuncIoIn;
      end else if (pick < 80) begin
        f = FuncIoOut;
        if (pick < 66) begin
          a[3:0] = PortPage;
          case ($urandom_range(7))
            0, 1: d = '0;
            2: ;
            default: d = DataW'($urandom_range(RamPageCount + 2, 1));
          endcase
        end
      end else if (pick < 90) begin
        f = FuncTick;
      end else if (pick < 94) begin
        f = FuncHostCmd;
      end else if (pick < 98) begin
        f = FuncHostData;
      end else begin
        f = FuncUnused;
      end
      issue_req(f, a, d);
      counted++;
    end
    steady     = 1'b0;
    in_valid_i <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
